[rtl/plist_pkg.sv]
// Package for the positional list engine.
// Holds request and status codes, the cell operation codes and the command
// struct broadcast to the cell chain. No dependencies.
package plist_pkg;

  // Width of counts and indexes; covers capacities up to 127 entries.
  localparam int unsigned CNT_W = 7;

  typedef enum logic [2:0] {
    REQ_INS_FRONT = 3'd0,
    REQ_INS_BACK  = 3'd1,
    REQ_INS_AT    = 3'd2,
    REQ_DEL_FRONT = 3'd3,
    REQ_DEL_BACK  = 3'd4,
    REQ_DEL_AT    = 3'd5,
    REQ_DUMP      = 3'd6,
    REQ_NOP       = 3'd7
  } req_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_BADPOS = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_FULL   = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_DELETE = 2'd2,
    CELL_ROTATE = 2'd3
  } cell_op_e;

  typedef struct packed {
    cell_op_e           op;
    logic [CNT_W-1:0]   idx;    // zero-based target index
    logic [CNT_W-1:0]   count;  // entries held before the operation
  } cell_cmd_t;

endpackage

[rtl/plist_cell.sv]
// One cell of the list chain: holds one entry and takes a neighbor's, the head's or the new value.
// Depends on plist_pkg.
module plist_cell #(
  parameter int unsigned DATA_WIDTH = 32,
  parameter int unsigned IDX        = 0
) (
  input  logic                  clk_i,
  input  plist_pkg::cell_cmd_t  cmd_i,
  input  logic [DATA_WIDTH-1:0] left_i,
  input  logic [DATA_WIDTH-1:0] right_i,
  input  logic [DATA_WIDTH-1:0] head_i,
  input  logic [DATA_WIDTH-1:0] new_i,
  output logic [DATA_WIDTH-1:0] data_o
);
  import plist_pkg::*;

  localparam logic [CNT_W-1:0] MyIdx  = CNT_W'(IDX);
  localparam logic [CNT_W-1:0] MyNext = CNT_W'(IDX + 1);

  logic [DATA_WIDTH-1:0] data_q, data_d;

  always_comb begin
    data_d = data_q;
    case (cmd_i.op)
      CELL_INSERT: begin
        if (MyIdx > cmd_i.idx) begin
          data_d = left_i;
        end else if (MyIdx == cmd_i.idx) begin
          data_d = new_i;
        end
      end
      CELL_DELETE: begin
        if (MyIdx >= cmd_i.idx) begin
          data_d = right_i;
        end
      end
      CELL_ROTATE: begin
        // occupied segment turns one place toward the head
        if (MyNext == cmd_i.count) begin
          data_d = head_i;
        end else if (MyNext < cmd_i.count) begin
          data_d = right_i;
        end
      end
      default: data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

[rtl/positional_list_engine.sv]
// A request is taken only while idle and registered into the execute state; its
// result is registered from there and strobes on the result outputs. An insert
// or delete frees the block after its execute state; a dump strobes one entry per
// cycle and frees the block as its last entry strobes. Inserts and deletes shift the whole cell chain at once.
// Reset clears the entry count and the control state; cell contents are kept.
// Results cannot be stalled by the receiver.
module positional_list_engine #(
  parameter int unsigned CAPACITY   = 32,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  req_type_i,
  input  logic [5:0]  position_i,
  input  logic [31:0] value_i,
  output logic        result_valid_o,
  output logic [1:0]  status_o,
  output logic [5:0]  entry_count_o,
  output logic [31:0] entry_value_o,
  output logic [5:0]  entry_position_o,
  output logic        entry_present_o,
  output logic        last_o
);
  import plist_pkg::*;

  localparam int unsigned CW = $clog2(CAPACITY + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_DUMP = 2'd2;

  logic [1:0]            state_q, state_d;
  logic [CW-1:0]         count_q, count_d;
  logic [CW-1:0]         idx_q, idx_d;
  logic [2:0]            req_q;
  logic [5:0]            pos_q;
  logic [DATA_WIDTH-1:0] val_q, val_fit;

  logic                  res_valid_q, res_valid_d;
  logic [1:0]            res_status_q, res_status_d;
  logic [5:0]            res_count_q, res_count_d;
  logic [31:0]           res_value_q, res_value_d;
  logic [5:0]            res_pos_q, res_pos_d;
  logic                  res_present_q, res_present_d;
  logic                  res_last_q, res_last_d;

  cell_cmd_t             cmd;
  logic [DATA_WIDTH-1:0] cell_data [CAPACITY];
  logic [31:0]           head32;

  logic [CNT_W-1:0]      cnt7, pos7, dump_idx7, dump_next7, cnt_new7;
  logic                  accept;

  assign accept = start && !busy;
  assign busy   = (state_q != S_IDLE);

  // stored width: truncate, or sign-extend from bit 31 when wider; read back sign-extended from DATA_WIDTH
  if (DATA_WIDTH >= 32) begin : g_wide
    assign val_fit = {{(DATA_WIDTH - 32){value_i[31]}}, value_i};
    assign head32  = cell_data[0][31:0];
  end else begin : g_narrow
    assign val_fit = value_i[DATA_WIDTH-1:0];
    assign head32  = {{(32 - DATA_WIDTH){cell_data[0][DATA_WIDTH-1]}}, cell_data[0]};
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] left, right;
    if (i == 0) begin : g_first
      assign left = val_q;
    end else begin : g_mid
      assign left = cell_data[i-1];
    end
    if (i == CAPACITY - 1) begin : g_end
      assign right = cell_data[i];
    end else begin : g_inner
      assign right = cell_data[i+1];
    end
    plist_cell #(
      .DATA_WIDTH(DATA_WIDTH),
      .IDX       (i)
    ) u_cell (
      .clk_i  (clk_i),
      .cmd_i  (cmd),
      .left_i (left),
      .right_i(right),
      .head_i (cell_data[0]),
      .new_i  (val_q),
      .data_o (cell_data[i])
    );
  end

  assign cnt7       = CNT_W'(count_q);
  assign pos7       = CNT_W'(pos_q);
  assign dump_idx7  = (state_q == S_EXEC) ? '0 : CNT_W'(idx_q);
  assign dump_next7 = dump_idx7 + CNT_W'(1);

  always_comb begin
    state_d       = state_q;
    count_d       = count_q;
    idx_d         = idx_q;
    cmd.op        = CELL_HOLD;
    cmd.idx       = '0;
    cmd.count     = cnt7;
    res_valid_d   = 1'b0;
    res_status_d  = ST_OK;
    res_value_d   = '0;
    res_pos_d     = '0;
    res_present_d = 1'b0;
    res_last_d    = 1'b1;
    cnt_new7      = cnt7;

    case (state_q)
      S_IDLE: begin
        if (start) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        res_valid_d = 1'b1;
        state_d     = S_IDLE;
        case (req_q)
          REQ_INS_FRONT, REQ_INS_BACK, REQ_INS_AT: begin
            if (cnt7 == CNT_W'(CAPACITY)) begin
              res_status_d = ST_FULL;
            end else if (req_q == REQ_INS_AT &&
                         (pos_q == '0 || pos7 > cnt7 + CNT_W'(1))) begin
              res_status_d = ST_BADPOS;
            end else begin
              cmd.op   = CELL_INSERT;
              cmd.idx  = (req_q == REQ_INS_FRONT) ? '0 :
                         (req_q == REQ_INS_BACK)  ? cnt7 : pos7 - CNT_W'(1);
              cnt_new7 = cnt7 + CNT_W'(1);
            end
          end
          REQ_DEL_FRONT, REQ_DEL_BACK, REQ_DEL_AT: begin
            if (cnt7 == '0) begin
              res_status_d = ST_EMPTY;
            end else if (req_q == REQ_DEL_AT && (pos_q == '0 || pos7 > cnt7)) begin
              res_status_d = ST_BADPOS;
            end else begin
              cmd.op   = CELL_DELETE;
              cmd.idx  = (req_q == REQ_DEL_FRONT) ? '0 :
                         (req_q == REQ_DEL_BACK)  ? cnt7 - CNT_W'(1) : pos7 - CNT_W'(1);
              cnt_new7 = cnt7 - CNT_W'(1);
            end
          end
          REQ_DUMP: begin
            if (cnt7 == '0) begin
              res_status_d = ST_EMPTY;
            end else begin
              cmd.op        = CELL_ROTATE;
              res_value_d   = head32;
              res_pos_d     = dump_next7[5:0];
              res_present_d = 1'b1;
              res_last_d    = (dump_next7 == cnt7);
              idx_d         = CW'(1);
              if (dump_next7 != cnt7) begin
                state_d = S_DUMP;
              end
            end
          end
          default: res_status_d = ST_OK;
        endcase
        count_d = CW'(cnt_new7);
      end
      S_DUMP: begin
        // head cell always holds the next entry; rotation restores order
        res_valid_d   = 1'b1;
        cmd.op        = CELL_ROTATE;
        res_value_d   = head32;
        res_pos_d     = dump_next7[5:0];
        res_present_d = 1'b1;
        res_last_d    = (dump_next7 == cnt7);
        idx_d         = CW'(dump_next7);
        if (dump_next7 == cnt7) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
    res_count_d = cnt_new7[5:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      idx_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      idx_q       <= idx_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= req_type_i;
      pos_q <= position_i;
      val_q <= val_fit;
    end
    res_status_q  <= res_status_d;
    res_count_q   <= res_count_d;
    res_value_q   <= res_value_d;
    res_pos_q     <= res_pos_d;
    res_present_q <= res_present_d;
    res_last_q    <= res_last_d;
  end

  assign result_valid_o   = res_valid_q;
  assign status_o         = res_status_q;
  assign entry_count_o    = res_count_q;
  assign entry_value_o    = res_value_q;
  assign entry_position_o = res_pos_q;
  assign entry_present_o  = res_present_q;
  assign last_o           = res_last_q;

endmodule

[rtl/plist_checker.sv]
// Port-level checks for the positional list engine, bound to the top level.
// Depends on plist_pkg and positional_list_engine.
module plist_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input logic        result_valid_o,
  input logic [1:0]  status_o,
  input logic [31:0] entry_value_o,
  input logic [5:0]  entry_position_o,
  input logic        entry_present_o,
  input logic        last_o
);
  import plist_pkg::*;

  // accepted request holds the block for its execute cycle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy && !result_valid_o)
    else $error("accepted request did not enter execution");

  // a dump that is not finished keeps the block busy
  a_dump_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !last_o |-> busy)
    else $error("partial dump while idle");

  a_no_entry_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !entry_present_o |-> entry_value_o == '0 && entry_position_o == '0)
    else $error("non-entry result carries entry data");

  a_error_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && status_o != ST_OK |-> last_o && !entry_present_o)
    else $error("error result not final");

  a_entry_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && entry_present_o |-> status_o == ST_OK && entry_position_o != '0)
    else $error("dumped entry with bad status or position");

endmodule

bind positional_list_engine plist_checker u_plist_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .start           (start),
  .busy            (busy),
  .result_valid_o  (result_valid_o),
  .status_o        (status_o),
  .entry_value_o   (entry_value_o),
  .entry_position_o(entry_position_o),
  .entry_present_o (entry_present_o),
  .last_o          (last_o)
);
